// ----- rtl/hfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hfc_pkg;
  typedef enum logic {
    OP_TO_HALF   = 1'b0,
    OP_TO_SINGLE = 1'b1
  } op_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] operand;
  } req_t;

  typedef struct packed {
    logic [31:0] converted;
    logic        overflow;
  } rsp_t;

  localparam logic [31:0] TinyLimit = 32'h3400_0000;
  localparam logic [7:0]  Rebias    = 8'h70;
  localparam logic [12:0] NanFill   = 13'h1FFF;

  // stage 1 -> stage 2 decode
  typedef struct packed {
    logic        op;
    logic        sign;
    logic        tiny;
    logic        ovf;
    logic        unf;
    logic [4:0]  h_exp;
    logic [9:0]  man10;
    logic [2:0]  h_kind;
    logic [3:0]  lz;
  } dec_t;

  localparam logic [2:0] KindNorm = 3'd0;
  localparam logic [2:0] KindZero = 3'd1;
  localparam logic [2:0] KindSub  = 3'd2;
  localparam logic [2:0] KindInf  = 3'd3;
  localparam logic [2:0] KindNan  = 3'd4;
endpackage
`default_nettype wire

// ----- rtl/hfc_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hfc_stage #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  stall_o,
  input  wire logic [Width-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output logic [Width-1:0]      data_o
);
  logic             valid_q;
  logic [Width-1:0] data_q;

  assign stall_o = valid_q && stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_i;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/half_float_converter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Converts between binary32 and binary16 bit patterns.
// Request channel: req_valid_i / req_stall_o / req_i (operation, operand).
//   operation 0 turns a single into a half (truncating, subnormals flushed,
//   too-large values give signed infinity with overflow set); operation 1
//   turns a half in operand[15:0] into an exact single (NaNs get ones in the low 13 mantissa bits).
// Response channel: rsp_valid_o / rsp_stall_i / rsp_o (converted, overflow).
// One request is taken every cycle while req_stall_o is low. The three
// register stages are decode and leading-zero count, field assembly,
// and the output register.
// Reset empties all stages; no response is pending afterward.
// When the receiver stalls, the stall backs up stage by stage; a stage
// whose register is empty still accepts, so bubbles are squeezed out and
// nothing is lost or repeated.
module half_float_converter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire hfc_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_stall_i,
  output hfc_pkg::rsp_t      rsp_o
);
  hfc_pkg::dec_t dec_d, dec_s;
  hfc_pkg::rsp_t asm_d, asm_s;
  logic v1, v2, st1, st2;

  always_comb begin
    logic [31:0] x;
    logic [8:0]  e;
    logic [9:0]  m;
    x = req_i.operand;
    e = '0;
    m = '0;
    dec_d = '0;
    dec_d.op = req_i.operation;
    if (req_i.operation == hfc_pkg::OP_TO_HALF) begin
      e = {1'b0, x[30:23]} - 9'd112;
      dec_d.sign  = x[31];
      dec_d.tiny  = ({1'b0, x[30:0]} <= hfc_pkg::TinyLimit);
      dec_d.ovf   = (x[30:23] >= 8'd143);
      dec_d.unf   = (x[30:23] <= 8'd112);
      dec_d.h_exp = e[4:0];
      dec_d.man10 = x[22:13];
    end else begin
      m = x[9:0];
      dec_d.sign  = x[15];
      dec_d.h_exp = x[14:10];
      dec_d.man10 = m;
      dec_d.lz    = 4'd10;
      for (int i = 0; i < 10; i++) begin
        if (m[i]) dec_d.lz = 4'(9 - i);
      end
      if (x[14:10] == 5'd0) begin
        dec_d.h_kind = (m == 10'd0) ? hfc_pkg::KindZero : hfc_pkg::KindSub;
      end else if (x[14:10] == 5'h1F) begin
        dec_d.h_kind = (m == 10'd0) ? hfc_pkg::KindInf : hfc_pkg::KindNan;
      end else begin
        dec_d.h_kind = hfc_pkg::KindNorm;
      end
    end
  end

  hfc_stage #(.Width($bits(hfc_pkg::dec_t))) u_s1 (
    .clk_i, .rst_ni, .valid_i(req_valid_i), .stall_o(req_stall_o),
    .data_i(dec_d), .valid_o(v1), .stall_i(st1), .data_o(dec_s)
  );

  always_comb begin
    logic [10:0] sh;
    asm_d = '0;
    sh = '0;
    if (dec_s.op == hfc_pkg::OP_TO_HALF) begin
      if (dec_s.tiny) begin
        asm_d.converted = '0;
      end else if (dec_s.ovf) begin
        asm_d.converted = {16'd0, dec_s.sign, 15'h7C00};
        asm_d.overflow  = 1'b1;
      end else if (dec_s.unf) begin
        asm_d.converted = {16'd0, dec_s.sign, 15'd0};
      end else begin
        asm_d.converted = {16'd0, dec_s.sign, dec_s.h_exp, dec_s.man10};
      end
    end else begin
      case (dec_s.h_kind)
        hfc_pkg::KindZero: asm_d.converted = {dec_s.sign, 31'd0};
        hfc_pkg::KindSub: begin
          sh = {1'b0, dec_s.man10} << (dec_s.lz + 4'd1);
          asm_d.converted = {dec_s.sign, hfc_pkg::Rebias - {4'd0, dec_s.lz},
                             sh[9:0], 13'd0};
        end
        hfc_pkg::KindInf: asm_d.converted = {dec_s.sign, 8'hFF, 23'd0};
        hfc_pkg::KindNan:
          asm_d.converted = {dec_s.sign, 8'hFF, dec_s.man10, hfc_pkg::NanFill};
        default:
          asm_d.converted = {dec_s.sign, {3'd0, dec_s.h_exp} + hfc_pkg::Rebias,
                             dec_s.man10, 13'd0};
      endcase
    end
  end

  hfc_stage #(.Width($bits(hfc_pkg::rsp_t))) u_s2 (
    .clk_i, .rst_ni, .valid_i(v1), .stall_o(st1),
    .data_i(asm_d), .valid_o(v2), .stall_i(st2), .data_o(asm_s)
  );

  hfc_stage #(.Width($bits(hfc_pkg::rsp_t))) u_s3 (
    .clk_i, .rst_ni, .valid_i(v2), .stall_o(st2),
    .data_i(asm_s), .valid_o(rsp_valid_o), .stall_i(rsp_stall_i), .data_o(rsp_o)
  );

  a_ovf_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.overflow |-> rsp_o.converted[14:0] == 15'h7C00)
    else $error("overflow without infinity");
  a_half_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2 && asm_s.overflow |-> asm_s.converted[31:16] == 16'd0)
    else $error("half result upper bits set");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled response changed");
endmodule
`default_nettype wire
